[hw/rtl/rdm_pkg.sv]
// Shared types, constants and codes of the residual desync monitor.
package rdm_pkg;

  localparam int HIST_BINS    = 8192;
  localparam int HIST_AW      = $clog2(HIST_BINS);
  localparam int PEAK_HISTORY = 5;
  localparam int PH_IW        = $clog2(PEAK_HISTORY + 1);
  localparam int PH_AW        = (PEAK_HISTORY > 1) ? $clog2(PEAK_HISTORY) : 1;
  localparam int CFG_AW       = 5;

  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;
  localparam logic [23:0] HUGE_Q8 = 24'd256000;
  localparam logic [15:0] BIN_MAX = 16'hFFFF;
  localparam logic [3:0]  BAD_MAX = 4'hF;

  localparam logic [19:0]        SLOPE_RST = 20'd209088;
  localparam logic [11:0]        CUT_RST   = 12'd40;
  localparam logic [9:0]         WIN_RST   = 10'd101;
  localparam logic [7:0]         RATIO_RST = 8'd5;
  localparam logic [15:0]        PLIM_RST  = 16'd768;
  localparam logic signed [14:0] HLOW_RST  = -15'sd2000;
  localparam logic signed [14:0] HHIGH_RST = 15'sd3000;
  localparam logic [3:0]         BLIM_RST  = 4'd3;
  localparam logic signed [24:0] PMEAN_RST = 25'sd19200;
  localparam logic [23:0]        AVG_RST   = 24'd2560000;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_HIT   = 1'b1;

  typedef enum logic [2:0] {
    V_ACCEPT  = 3'd0,
    V_WARN    = 3'd1,
    V_LOST    = 3'd2,
    V_EMPTY   = 3'd3,
    V_DISCARD = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    R_SLOPE = 3'd0,
    R_CUT   = 3'd1,
    R_WIN   = 3'd2,
    R_RATIO = 3'd3,
    R_PLIM  = 3'd4,
    R_HLOW  = 3'd5,
    R_HHIGH = 3'd6,
    R_BLIM  = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_RES, ST_UPD, ST_SQ,
    ST_DIV_MEAN, ST_WAIT_MEAN, ST_MEAN_SQ, ST_WAIT_SQ, ST_SQRT, ST_WAIT_SQRT,
    ST_DIV_PEAK, ST_WAIT_PEAK, ST_DECIDE, ST_AVG_SUM, ST_DIV_AVG, ST_WAIT_AVG,
    ST_OUT, ST_CLEAR
  } state_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic [63:0] a;
    logic [23:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [23:0] rem;
  } arith_rsp_t;

endpackage

[hw/rtl/rdm_ifs.sv]
// Handshake channels of the residual desync monitor.
interface rdm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] event_number;
  logic [11:0] dut_x;
  logic [11:0] tel_x;
  modport source(output valid, command, event_number, dut_x, tel_x, input ready);
  modport sink(input valid, command, event_number, dut_x, tel_x, output ready);
endinterface

interface rdm_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        eval_event;
  logic signed [24:0] mean_q8;
  logic [23:0]        sigma_q8;
  logic [23:0]        pair_count;
  logic [15:0]        peak_bin_count;
  logic [23:0]        peakness_q8;
  logic [2:0]         verdict;
  modport source(output valid, eval_event, mean_q8, sigma_q8, pair_count,
                 peak_bin_count, peakness_q8, verdict, input ready);
  modport sink(input valid, eval_event, mean_q8, sigma_q8, pair_count,
               peak_bin_count, peakness_q8, verdict, output ready);
endinterface

[hw/rtl/rdm_arith.sv]
// Shared bit-serial unit: 64/24 restoring divide and 64-bit integer square root.
module rdm_arith (
  input  logic               clk,
  input  logic               rst_n,
  input  rdm_pkg::arith_req_t req,
  output rdm_pkg::arith_rsp_t rsp
);
  import rdm_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  arith_op_t   op_r;
  logic [6:0]  cnt_r;
  logic [63:0] shf_r;
  logic [23:0] div_r;
  logic [23:0] rem_r;
  logic [33:0] sqrem_r;
  logic [31:0] root_r;

  logic [24:0] dtry;
  logic        dfit;
  logic [35:0] stry;
  logic [35:0] strial;
  logic        sfit;

  assign dtry   = {rem_r, shf_r[63]};
  assign dfit   = dtry >= {1'b0, div_r};
  assign stry   = {sqrem_r, shf_r[63:62]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sfit   = stry >= strial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == 7'd1) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r    <= req.op;
      shf_r   <= req.a;
      div_r   <= req.b;
      rem_r   <= '0;
      sqrem_r <= '0;
      root_r  <= '0;
      cnt_r   <= (req.op == OP_DIV) ? 7'd64 : 7'd32;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (op_r == OP_DIV) begin
        shf_r <= {shf_r[62:0], dfit};
        rem_r <= dfit ? 24'(dtry - {1'b0, div_r}) : dtry[23:0];
      end else begin
        shf_r   <= {shf_r[61:0], 2'b00};
        sqrem_r <= sfit ? 34'(stry - strial) : stry[33:0];
        root_r  <= {root_r[30:0], sfit};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = (op_r == OP_DIV) ? shf_r : {32'd0, root_r};
  assign rsp.rem  = rem_r;

endmodule

[hw/rtl/residual_desync_monitor_unit.sv]
// Residual desync monitor: window statistics, histogram peak and sync verdict.
// A hit pair runs from acceptance through multiply, residual and histogram
// read, histogram write-back and square accumulate. An event start that does
// not close the window is taken without leaving idle. One that closes it runs
// the evaluation on a shared bit-serial unit (divides for mean, mean square
// and peakness, a square root, decide and output), plus a sum over the
// peakness history and one more divide when that history wraps; an empty
// window goes straight to output. Then it clears the histogram memory one bin
// per cycle (all HIST_BINS = 8192 bins) before the next word is taken.
// The same clearing pass runs after reset. Configuration writes are
// taken at any time.
module residual_desync_monitor_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  rdm_in_if.sink                     in_ch,
  rdm_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rdm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import rdm_pkg::*;

  // configuration
  logic [19:0]        slope_r;
  logic [11:0]        cut_r;
  logic [9:0]         win_r;
  logic [7:0]         ratio_r;
  logic [15:0]        plim_r;
  logic signed [14:0] hlow_r;
  logic signed [14:0] hhigh_r;
  logic [3:0]         blim_r;
  logic               cfg_wr;
  cfg_idx_t           cfg_idx;

  state_t state_r, state_nxt;

  // window state
  logic [15:0]        hist_max_r;
  logic signed [47:0] res_sum_r;
  logic [63:0]        sq_sum_r;
  logic [23:0]        res_count_r;
  logic [9:0]         ev_cnt_r;
  logic               first_r;
  logic signed [24:0] pmean_r;
  logic [23:0]        avg_r;
  logic [23:0]        ph_r [PEAK_HISTORY];
  logic [PH_IW-1:0]   hidx_r;
  logic [3:0]         bad_r;
  logic               sync_r;

  // hit path
  logic [11:0]        dut_r, tel_r;
  logic [31:0]        prod_r;
  logic signed [25:0] res_r;
  logic               keep_r, binok_r;
  logic [HIST_AW-1:0] bin_r;
  logic [51:0]        sq_r;

  // evaluation
  logic [31:0]        ev_num_r;
  logic               empty_r;
  logic signed [24:0] mean_r;
  logic [49:0]        m2_r;
  logic [63:0]        var_r;
  logic [23:0]        sigma_r;
  logic [23:0]        peak_r;
  verdict_t           verdict_r;
  logic [PH_IW-1:0]   avg_i_r;
  logic [23+PH_IW:0]  avg_s_r;
  logic [PH_IW-1:0]   avg_n_r;
  logic [HIST_AW-1:0] clr_r;

  // output register
  logic               out_valid_r;
  logic [31:0]        o_event_r;
  logic signed [24:0] o_mean_r;
  logic [23:0]        o_sigma_r, o_count_r, o_peak_r;
  logic [15:0]        o_pbin_r;
  verdict_t           o_verdict_r;

  // histogram memory
  logic [15:0]        hist_mem [HIST_BINS];
  logic [15:0]        hist_rd_r;
  logic               hist_we, hist_re;
  logic [HIST_AW-1:0] hist_waddr;
  logic [15:0]        hist_wdata;

  arith_req_t arq;
  arith_rsp_t ars;

  logic in_acc, out_load, eval_c;

  // residual math
  logic signed [33:0] r16;
  logic signed [33:0] r16r;
  logic signed [25:0] res_c;
  logic signed [17:0] px_c;
  logic signed [26:0] r27, lo27, hi27, cut27;
  logic signed [19:0] bin_c;
  logic               keep_c, binok_c;
  logic [15:0]        newc;
  logic signed [48:0] sum49;
  logic [64:0]        sq65;
  logic [31:0]        thr;
  logic               desync_c, huge_c, wrap_c;
  logic [PH_IW-1:0]   widx;
  logic [3:0]         bad_inc;
  logic               lost_c;
  logic [64:0]        mag;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r <= SLOPE_RST;
      cut_r   <= CUT_RST;
      win_r   <= WIN_RST;
      ratio_r <= RATIO_RST;
      plim_r  <= PLIM_RST;
      hlow_r  <= HLOW_RST;
      hhigh_r <= HHIGH_RST;
      blim_r  <= BLIM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        R_SLOPE: slope_r <= cfg_pwdata[19:0];
        R_CUT:   cut_r   <= cfg_pwdata[11:0];
        R_WIN:   win_r   <= cfg_pwdata[9:0];
        R_RATIO: ratio_r <= cfg_pwdata[7:0];
        R_PLIM:  plim_r  <= cfg_pwdata[15:0];
        R_HLOW:  hlow_r  <= cfg_pwdata[14:0];
        R_HHIGH: hhigh_r <= cfg_pwdata[14:0];
        R_BLIM:  blim_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      R_SLOPE: cfg_prdata = {12'd0, slope_r};
      R_CUT:   cfg_prdata = {20'd0, cut_r};
      R_WIN:   cfg_prdata = {22'd0, win_r};
      R_RATIO: cfg_prdata = {24'd0, ratio_r};
      R_PLIM:  cfg_prdata = {16'd0, plim_r};
      R_HLOW:  cfg_prdata = {17'd0, hlow_r};
      R_HHIGH: cfg_prdata = {17'd0, hhigh_r};
      R_BLIM:  cfg_prdata = {28'd0, blim_r};
      default: cfg_prdata = '0;
    endcase
  end

  // residual, cut window and bin
  assign r16   = $signed({2'b00, dut_r, 16'd0}) - $signed({2'b00, prod_r});
  assign r16r  = r16 + 34'sd128;
  assign res_c = r16r[33:8];
  assign px_c  = res_c[25:8];
  assign r27   = 27'(res_c);
  assign cut27 = $signed({7'd0, cut_r, 8'd0});
  assign lo27  = 27'(pmean_r) - cut27;
  assign hi27  = 27'(pmean_r) + cut27;
  assign bin_c = 20'(px_c) - 20'(hlow_r);
  assign keep_c  = (first_r || (r27 <= hi27 && r27 >= lo27)) && res_count_r != CNT_MAX;
  assign binok_c = keep_c && (px_c < 18'(hhigh_r)) && (bin_c >= 20'sd0)
                   && (bin_c < $signed(20'(HIST_BINS)));

  assign newc  = (hist_rd_r == BIN_MAX) ? hist_rd_r : hist_rd_r + 16'd1;
  assign sum49 = 49'(res_sum_r) + 49'(res_r);
  assign sq65  = {1'b0, sq_sum_r} + 65'(sq_r);

  // verdict
  assign thr      = ratio_r * avg_r;
  assign desync_c = ({8'd0, peak_r} > thr) || (peak_r > {8'd0, plim_r});
  assign huge_c   = peak_r > HUGE_Q8;
  assign wrap_c   = hidx_r >= PH_IW'(PEAK_HISTORY);
  assign widx     = wrap_c ? '0 : hidx_r;
  assign bad_inc  = (bad_r == BAD_MAX) ? bad_r : bad_r + 4'd1;
  assign lost_c   = bad_inc > blim_r;
  assign mag      = {1'b0, ars.quo} + 65'(ars.rem != 24'd0);

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = state_r == ST_OUT && (!out_valid_r || out_ch.ready);
  assign eval_c   = ({1'b0, ev_cnt_r} + 11'd1) > {1'b0, win_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_HIT) begin
            state_nxt = ST_MUL;
          end else if (eval_c) begin
            state_nxt = (hist_max_r == 16'd0) ? ST_OUT : ST_DIV_MEAN;
          end
        end
      end
      ST_MUL:       state_nxt = ST_RES;
      ST_RES:       state_nxt = ST_UPD;
      ST_UPD:       state_nxt = ST_SQ;
      ST_SQ:        state_nxt = ST_IDLE;
      ST_DIV_MEAN:  state_nxt = ST_WAIT_MEAN;
      ST_WAIT_MEAN: state_nxt = ars.done ? ST_MEAN_SQ : ST_WAIT_MEAN;
      ST_MEAN_SQ:   state_nxt = ST_WAIT_SQ;
      ST_WAIT_SQ:   state_nxt = ars.done ? ST_SQRT : ST_WAIT_SQ;
      ST_SQRT:      state_nxt = ST_WAIT_SQRT;
      ST_WAIT_SQRT: state_nxt = ars.done ? ST_DIV_PEAK : ST_WAIT_SQRT;
      ST_DIV_PEAK:  state_nxt = ST_WAIT_PEAK;
      ST_WAIT_PEAK: state_nxt = ars.done ? ST_DECIDE : ST_WAIT_PEAK;
      ST_DECIDE: begin
        state_nxt = (!desync_c && !huge_c && wrap_c) ? ST_AVG_SUM : ST_OUT;
      end
      ST_AVG_SUM: begin
        if (avg_i_r == PH_IW'(PEAK_HISTORY - 1)) state_nxt = ST_DIV_AVG;
      end
      ST_DIV_AVG:   state_nxt = (avg_n_r == '0) ? ST_OUT : ST_WAIT_AVG;
      ST_WAIT_AVG:  state_nxt = ars.done ? ST_OUT : ST_WAIT_AVG;
      ST_OUT:       state_nxt = out_load ? ST_CLEAR : ST_OUT;
      ST_CLEAR: begin
        if (clr_r == HIST_AW'(HIST_BINS - 1)) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = state_r == ST_IDLE;
    hist_re     = state_r == ST_RES;
    hist_we     = 1'b0;
    hist_waddr  = bin_r;
    hist_wdata  = newc;
    arq.start   = 1'b0;
    arq.op      = OP_DIV;
    arq.a       = '0;
    arq.b       = res_count_r;
    case (state_r)
      ST_UPD: hist_we = binok_r;
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_r;
        hist_wdata = '0;
      end
      ST_DIV_MEAN: begin
        arq.start = 1'b1;
        arq.a     = res_sum_r[47] ? {16'd0, 48'(-res_sum_r)} : {16'd0, res_sum_r};
      end
      ST_MEAN_SQ: begin
        arq.start = 1'b1;
        arq.a     = sq_sum_r;
      end
      ST_SQRT: begin
        arq.start = 1'b1;
        arq.op    = OP_SQRT;
        arq.a     = var_r;
      end
      ST_DIV_PEAK: begin
        arq.start = 1'b1;
        arq.a     = 64'(sigma_r);
        arq.b     = 24'(hist_max_r);
      end
      ST_DIV_AVG: begin
        arq.start = avg_n_r != '0;
        arq.a     = 64'(avg_s_r);
        arq.b     = 24'(avg_n_r);
      end
      default: ;
    endcase
  end

  rdm_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arq),
    .rsp   (ars)
  );

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_rd_r <= hist_mem[bin_c[HIST_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hist_max_r  <= '0;
      res_sum_r   <= '0;
      sq_sum_r    <= '0;
      res_count_r <= '0;
      ev_cnt_r    <= '0;
      first_r     <= 1'b1;
      pmean_r     <= PMEAN_RST;
      avg_r       <= AVG_RST;
      hidx_r      <= '0;
      bad_r       <= '0;
      sync_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PEAK_HISTORY; i++) ph_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_ch.command == CMD_EVENT) begin
            ev_cnt_r <= eval_c ? '0 : ev_cnt_r + 10'd1;
          end
        end
        ST_UPD: begin
          if (keep_r) begin
            res_count_r <= res_count_r + 24'd1;
            if (sum49[48] != sum49[47]) begin
              res_sum_r <= sum49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end else begin
              res_sum_r <= sum49[47:0];
            end
          end
          if (binok_r && newc > hist_max_r) hist_max_r <= newc;
        end
        ST_SQ: begin
          if (keep_r) sq_sum_r <= sq65[64] ? '1 : sq65[63:0];
        end
        ST_DECIDE: begin
          if (desync_c) begin
            bad_r <= bad_inc;
            if (lost_c) sync_r <= 1'b1;
          end else if (!huge_c) begin
            ph_r[widx[PH_AW-1:0]] <= peak_r;
            hidx_r  <= widx + PH_IW'(1);
            if (bad_r != 4'd0) bad_r <= bad_r - 4'd1;
            pmean_r <= mean_r;
          end
        end
        ST_WAIT_AVG: begin
          if (ars.done && ars.quo != 64'd0) avg_r <= ars.quo[23:0];
        end
        ST_OUT: begin
          if (out_load) begin
            clr_r       <= '0;
            hist_max_r  <= '0;
            res_sum_r   <= '0;
            sq_sum_r    <= '0;
            res_count_r <= '0;
            first_r     <= 1'b0;
          end
        end
        ST_CLEAR: clr_r <= clr_r + HIST_AW'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ev_num_r <= in_ch.event_number;
        empty_r  <= hist_max_r == 16'd0;
        dut_r    <= in_ch.dut_x;
        tel_r    <= in_ch.tel_x;
      end
      ST_MUL: prod_r <= slope_r * tel_r;
      ST_RES: begin
        res_r   <= res_c;
        keep_r  <= keep_c;
        binok_r <= binok_c;
        bin_r   <= bin_c[HIST_AW-1:0];
      end
      ST_UPD: sq_r <= 52'(res_r * res_r);
      ST_WAIT_MEAN: begin
        if (ars.done) begin
          if (!res_sum_r[47]) begin
            mean_r <= (ars.quo > 64'hFFFFFF) ? 25'sh0FFFFFF : $signed({1'b0, ars.quo[23:0]});
          end else begin
            mean_r <= (mag > 65'h1000000) ? 25'sh1000000 : 25'(-$signed({1'b0, mag[24:0]}));
          end
        end
      end
      ST_MEAN_SQ: m2_r <= 50'(mean_r * mean_r);
      ST_WAIT_SQ: begin
        if (ars.done) var_r <= (ars.quo > 64'(m2_r)) ? ars.quo - 64'(m2_r) : '0;
      end
      ST_WAIT_SQRT: begin
        if (ars.done) sigma_r <= (ars.quo > 64'(CNT_MAX)) ? CNT_MAX : ars.quo[23:0];
      end
      ST_WAIT_PEAK: begin
        if (ars.done) peak_r <= ars.quo[23:0];
      end
      ST_DECIDE: begin
        avg_i_r <= '0;
        avg_s_r <= '0;
        avg_n_r <= '0;
        if (desync_c) begin
          verdict_r <= (sync_r || lost_c) ? V_LOST : V_WARN;
        end else if (huge_c) begin
          verdict_r <= sync_r ? V_LOST : V_DISCARD;
        end else begin
          verdict_r <= sync_r ? V_LOST : V_ACCEPT;
        end
      end
      ST_AVG_SUM: begin
        avg_i_r <= avg_i_r + PH_IW'(1);
        if (ph_r[avg_i_r[PH_AW-1:0]] != 24'd0) begin
          avg_s_r <= avg_s_r + (24 + PH_IW)'(ph_r[avg_i_r[PH_AW-1:0]]);
          avg_n_r <= avg_n_r + PH_IW'(1);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          o_event_r <= ev_num_r;
          o_count_r <= res_count_r;
          if (empty_r) begin
            o_mean_r    <= '0;
            o_sigma_r   <= '0;
            o_pbin_r    <= '0;
            o_peak_r    <= '0;
            o_verdict_r <= sync_r ? V_LOST : V_EMPTY;
          end else begin
            o_mean_r    <= mean_r;
            o_sigma_r   <= sigma_r;
            o_pbin_r    <= hist_max_r;
            o_peak_r    <= peak_r;
            o_verdict_r <= verdict_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.eval_event     = o_event_r;
  assign out_ch.mean_q8        = o_mean_r;
  assign out_ch.sigma_q8       = o_sigma_r;
  assign out_ch.pair_count     = o_count_r;
  assign out_ch.peak_bin_count = o_pbin_r;
  assign out_ch.peakness_q8    = o_peak_r;
  assign out_ch.verdict        = o_verdict_r;

  a_sync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(sync_r) |-> sync_r) else $error("sync lost flag dropped");

  a_max_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    hist_max_r != 16'd0 |-> res_count_r != 24'd0) else $error("peak bin without residuals");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == ST_IDLE) else $error("word accepted while busy");

  a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT)) else $error("result without evaluation");

endmodule
